@@ src/simv_breath_cycle_sequencer_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Breath cycle sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SIMV_BREATH_CYCLE_SEQUENCER_UNIT_MACROS_SVH
`define SIMV_BREATH_CYCLE_SEQUENCER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BCS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bcs_pkg.sv @@
// ---------------------------------------------------------------------------
// Breath cycle sequencer package
// Types, codes and the breath period lookup shared by the sequencer files.
// ---------------------------------------------------------------------------
package bcs_pkg;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONTROL_RATE = 3'd0,
		CFG_BACKUP_RATE  = 3'd1,
		CFG_TI_CONTROL   = 3'd2,
		CFG_INIT_DELAY   = 3'd3,
		CFG_APNEA_EXIT   = 3'd4
	} cfg_idx_t;

	// Reset values of the configuration registers
	localparam logic [15:0] RST_PERIOD     = 16'd4000;
	localparam logic [13:0] RST_TI_CONTROL = 14'd1000;
	localparam logic [15:0] RST_INIT_DELAY = 16'd2000;
	localparam logic [1:0]  RST_APNEA_EXIT = 2'd2;

	// Breath state machine phases
	typedef enum logic [2:0] {
		ST_START    = 3'd0,
		ST_EXH      = 3'd1,
		ST_ASSIST   = 3'd2,
		ST_PSV      = 3'd3,
		ST_CV       = 3'd4,
		ST_CV_APNEA = 3'd5,
		ST_EXH_APNEA = 3'd6,
		ST_LEFT     = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		INSP_NONE = 2'd0,
		INSP_TRIG = 2'd1,
		INSP_CTRL = 2'd2
	} insp_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_ASSIST  = 2'd1,
		KIND_CONTROL = 2'd2,
		KIND_SUPPORT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		HIST_NONE    = 2'd0,
		HIST_ASSIST  = 2'd1,
		HIST_SUPPORT = 2'd2,
		HIST_CONTROL = 2'd3
	} hist_t;

	typedef enum logic [1:0] {
		PSEND_NONE  = 2'd0,
		PSEND_TIMED = 2'd1,
		PSEND_HIGHP = 2'd2,
		PSEND_FLOW  = 2'd3
	} psend_t;

	// One time step on the input stream
	typedef struct packed {
		logic [15:0] ti_max_ms;
		logic [15:0] ti_min_ms;
		logic        apnea_alarm;
		logic        high_pressure;
		logic        exp_trigger;
		logic        insp_trigger;
		logic        restart_mode;
		logic [7:0]  elapsed_ms;
	} in_item_t;

	// One result on the output stream
	typedef struct packed {
		logic        apnea_restart;
		logic [2:0]  ps_end_slot;
		psend_t      ps_end_code;
		logic [2:0]  history_slot;
		hist_t       history_code;
		logic [15:0] te_measured;
		logic [15:0] ti_measured;
		phase_t      phase;
		logic        controlled_flag;
		kind_t       breath_kind;
		insp_t       insp_type;
	} result_t;

	// Active settings seen by the sequencer core
	typedef struct packed {
		logic [15:0] ctl_period;
		logic [15:0] bkp_period;
		logic [13:0] ti_ctl;
		logic [15:0] init_delay;
		logic [1:0]  exit_count;
	} cfg_t;

	// Breath period in ms for a rate in breaths per minute; rate 0 acts as 1
	function automatic logic [15:0] period_lut(input logic [5:0] rate);
		logic [15:0] p;
		unique case (rate)
			6'd0, 6'd1: p = 16'd60000;
			6'd2:  p = 16'd30000;
			6'd3:  p = 16'd20000;
			6'd4:  p = 16'd15000;
			6'd5:  p = 16'd12000;
			6'd6:  p = 16'd10000;
			6'd7:  p = 16'd8571;
			6'd8:  p = 16'd7500;
			6'd9:  p = 16'd6666;
			6'd10: p = 16'd6000;
			6'd11: p = 16'd5454;
			6'd12: p = 16'd5000;
			6'd13: p = 16'd4615;
			6'd14: p = 16'd4285;
			6'd15: p = 16'd4000;
			6'd16: p = 16'd3750;
			6'd17: p = 16'd3529;
			6'd18: p = 16'd3333;
			6'd19: p = 16'd3157;
			6'd20: p = 16'd3000;
			6'd21: p = 16'd2857;
			6'd22: p = 16'd2727;
			6'd23: p = 16'd2608;
			6'd24: p = 16'd2500;
			6'd25: p = 16'd2400;
			6'd26: p = 16'd2307;
			6'd27: p = 16'd2222;
			6'd28: p = 16'd2142;
			6'd29: p = 16'd2068;
			6'd30: p = 16'd2000;
			6'd31: p = 16'd1935;
			6'd32: p = 16'd1875;
			6'd33: p = 16'd1818;
			6'd34: p = 16'd1764;
			6'd35: p = 16'd1714;
			6'd36: p = 16'd1666;
			6'd37: p = 16'd1621;
			6'd38: p = 16'd1578;
			6'd39: p = 16'd1538;
			6'd40: p = 16'd1500;
			6'd41: p = 16'd1463;
			6'd42: p = 16'd1428;
			6'd43: p = 16'd1395;
			6'd44: p = 16'd1363;
			6'd45: p = 16'd1333;
			6'd46: p = 16'd1304;
			6'd47: p = 16'd1276;
			6'd48: p = 16'd1250;
			6'd49: p = 16'd1224;
			6'd50: p = 16'd1200;
			6'd51: p = 16'd1176;
			6'd52: p = 16'd1153;
			6'd53: p = 16'd1132;
			6'd54: p = 16'd1111;
			6'd55: p = 16'd1090;
			6'd56: p = 16'd1071;
			6'd57: p = 16'd1052;
			6'd58: p = 16'd1034;
			6'd59: p = 16'd1016;
			6'd60: p = 16'd1000;
			6'd61: p = 16'd983;
			6'd62: p = 16'd967;
			6'd63: p = 16'd952;
			default: p = 16'd60000;
		endcase
		return p;
	endfunction

endpackage

@@ src/simv_breath_cycle_sequencer_unit.sv @@
// ---------------------------------------------------------------------------
// Volume SIMV breath cycle sequencer
// Steps the breath state machine once per time-step transaction.
// ---------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_ stream is one time step (elapsed ms, patient
//   triggers, alarms, PSV Ti limits). Each step yields exactly one result
//   transaction on the m_ stream (inspiration type, breath kind, phase,
//   measured Ti/Te, history and PSV end ring slots, apnea restart pulse).
//   Settings are written through cfg_we/cfg_idx/cfg_wdata while no step is
//   in flight; a rate write is converted to its period in the same edge.
//   A step is captured in an input register, then the state machine runs and
//   the result register loads. Throughput is one step per cycle while m_tready
//   is high or the result register is empty; the state update is combinational
//   compares and adds, so back-to-back steps wait only on a stalled result.
//   When m_tready is low the result holds, one more step can still be taken
//   into the input register, and s_tready drops only when both are full.
//   Reset (arst_n low) clears the counters, returns to start-up and restores
//   the default settings (both rates 15/min, Ti 1000 ms, delay 2000 ms,
//   exit count 2).
// ---------------------------------------------------------------------------
module simv_breath_cycle_sequencer_unit #(
	parameter int RING_DEPTH = 6,
	parameter int COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// elapsed_ms, restart_mode, insp_trigger, exp_trigger, high_pressure,
	// apnea_alarm, ti_min_ms, ti_max_ms
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bcs_pkg::IN_DATA_W-1:0]   s_tdata,
	// insp_type, breath_kind, controlled_flag, phase, ti_measured,
	// te_measured, history_code, history_slot, ps_end_code, ps_end_slot,
	// apnea_restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bcs_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            cfg_we,
	input  logic [bcs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import bcs_pkg::*;

	cfg_t     cfg;
	in_item_t item_s1;
	logic     vld_s1;
	result_t  res;
	result_t  res_q;
	logic     mvld_q;
	logic     adv;

	// Pipeline moves when the result register is free or being drained
	assign adv      = !mvld_q || m_tready;
	assign s_tready = !vld_s1 || adv;

	bcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bcs_core #(
		.RING_DEPTH (RING_DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv && vld_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvld_q <= 1'b0;
		end else if (adv) begin
			mvld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = mvld_q;
	assign m_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), res_q};

endmodule

@@ src/bcs_cfg.sv @@
// ---------------------------------------------------------------------------
// Breath cycle sequencer configuration registers
// Holds the settings and converts both rates to periods on write.
// ---------------------------------------------------------------------------
module bcs_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bcs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bcs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output bcs_pkg::cfg_t                   cfg
);
	import bcs_pkg::*;

	cfg_t cfg_q;

	// Write one register; rates are stored as their period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctl_period <= RST_PERIOD;
			cfg_q.bkp_period <= RST_PERIOD;
			cfg_q.ti_ctl     <= RST_TI_CONTROL;
			cfg_q.init_delay <= RST_INIT_DELAY;
			cfg_q.exit_count <= RST_APNEA_EXIT;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_CONTROL_RATE: cfg_q.ctl_period <= period_lut(cfg_wdata[5:0]);
				CFG_BACKUP_RATE:  cfg_q.bkp_period <= period_lut(cfg_wdata[5:0]);
				CFG_TI_CONTROL:   cfg_q.ti_ctl     <= cfg_wdata[13:0];
				CFG_INIT_DELAY:   cfg_q.init_delay <= cfg_wdata;
				CFG_APNEA_EXIT:   cfg_q.exit_count <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/bcs_core.sv @@
// ---------------------------------------------------------------------------
// Breath cycle sequencer core
// Millisecond counters and the SIMV breath state machine, one step a cycle while step is high.
// ---------------------------------------------------------------------------
module bcs_core #(
	parameter int RING_DEPTH = 6,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  bcs_pkg::in_item_t   item,
	input  bcs_pkg::cfg_t       cfg,
	output bcs_pkg::result_t    res
);
	import bcs_pkg::*;

	localparam int IW = $clog2(RING_DEPTH);
	localparam int XW = COUNT_BITS + 2;
	localparam logic [IW-1:0] LAST_SLOT = IW'(RING_DEPTH - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// State registers
	phase_t                phase_q, phase_d;
	logic                  fbs_q, fbs_d;
	logic [COUNT_BITS-1:0] te_q, te_d, ti_q, ti_d, pc_q, pc_d;
	logic [COUNT_BITS-1:0] exh_q, exh_d, til_q, til_d, tel_q, tel_d;
	logic [IW-1:0]         hidx_q, hidx_d, pidx_q, pidx_d;
	logic                  psv_q, psv_d, mdel_q, mdel_d, mcan_q, mcan_d;
	logic [1:0]            tally_q, tally_d;

	// Step events
	insp_t  ins;
	kind_t  kind;
	hist_t  hc;
	psend_t pcode;
	logic   ctl, ar, breath;

	// Advanced counters and compares
	logic [COUNT_BITS-1:0] te_a, ti_a, pc_a;
	logic [XW-1:0]         pc_x, ctl_x, bkp_x, late_mark, end_mark;
	logic signed [XW-1:0]  psv_lim;
	logic                  pc_lt_ctl, pc_lt_late, pc_lt_bkp, pc_lt_psv;
	logic                  ti_done, psv_end, psv_timed;
	phase_t                phase_in;
	logic                  fbs_in;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
		input logic [7:0] e);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + (COUNT_BITS+1)'(e);
		return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
		return (i == LAST_SLOT) ? '0 : i + IW'(1);
	endfunction

	// Advance the counters and apply restart
	assign te_a     = sat_add(te_q, item.elapsed_ms);
	assign ti_a     = sat_add(ti_q, item.elapsed_ms);
	assign pc_a     = sat_add(pc_q, item.elapsed_ms);
	assign phase_in = item.restart_mode ? ST_START : phase_q;
	assign fbs_in   = item.restart_mode ? 1'b0 : fbs_q;

	// Period window compares
	assign pc_x       = XW'(pc_a);
	assign ctl_x      = XW'(cfg.ctl_period);
	assign bkp_x      = XW'(cfg.bkp_period);
	assign late_mark  = XW'(exh_q) + (XW'(til_q) << 1);
	assign end_mark   = pc_x + (XW'(ti_a) << 1);
	assign psv_lim    = signed'(ctl_x - XW'(cfg.ti_ctl));
	assign pc_lt_psv  = $signed(pc_x) < psv_lim;
	assign pc_lt_ctl  = pc_x < ctl_x;
	assign pc_lt_late = pc_x < late_mark;
	assign pc_lt_bkp  = pc_x < bkp_x;
	assign ti_done    = (ti_a >= COUNT_BITS'(cfg.ti_ctl)) || item.high_pressure;
	assign psv_timed  = ti_a >= COUNT_BITS'(item.ti_max_ms);
	assign psv_end    = (item.exp_trigger && (ti_a >= COUNT_BITS'(item.ti_min_ms)))
		|| psv_timed || item.high_pressure;

	// Next state and step events
	always_comb begin
		phase_d = phase_in;
		fbs_d   = fbs_in;
		te_d    = te_a;
		ti_d    = ti_a;
		pc_d    = pc_a;
		exh_d   = exh_q;
		til_d   = til_q;
		tel_d   = tel_q;
		hidx_d  = hidx_q;
		pidx_d  = pidx_q;
		psv_d   = psv_q;
		mdel_d  = mdel_q;
		mcan_d  = mcan_q;
		tally_d = tally_q;
		ins     = INSP_NONE;
		kind    = KIND_NONE;
		hc      = HIST_NONE;
		pcode   = PSEND_NONE;
		ctl     = 1'b0;
		ar      = 1'b0;
		breath  = 1'b0;

		unique case (phase_in)
			ST_START: begin
				if (!fbs_in) begin
					fbs_d = 1'b1;
					te_d  = '0;
					kind  = KIND_ASSIST;
					ar    = 1'b1;
				end else if (item.insp_trigger) begin
					ti_d    = '0;
					pc_d    = '0;
					mcan_d  = 1'b0;
					ins     = INSP_TRIG;
					kind    = KIND_ASSIST;
					phase_d = ST_ASSIST;
					ar      = 1'b1;
				end else if (te_a >= COUNT_BITS'(cfg.init_delay)) begin
					ti_d    = '0;
					pc_d    = '0;
					mcan_d  = 1'b0;
					ins     = INSP_CTRL;
					kind    = KIND_CONTROL;
					phase_d = ST_CV;
					ar      = 1'b1;
				end
			end
			ST_EXH: begin
				if (item.insp_trigger) begin
					if (pc_lt_psv) begin
						ins     = INSP_TRIG;
						kind    = KIND_SUPPORT;
						phase_d = ST_PSV;
						psv_d   = 1'b1;
						breath  = 1'b1;
					end else if (pc_lt_ctl || (pc_lt_late && mdel_q)) begin
						ins     = INSP_TRIG;
						kind    = KIND_ASSIST;
						phase_d = ST_ASSIST;
						mcan_d  = 1'b1;
						mdel_d  = 1'b0;
						hc      = psv_q ? HIST_SUPPORT : HIST_ASSIST;
						psv_d   = 1'b0;
						breath  = 1'b1;
					end
				end else if (!mcan_q && ((!pc_lt_ctl && !mdel_q) ||
						(!pc_lt_late && mdel_q))) begin
					ins     = INSP_CTRL;
					kind    = KIND_CONTROL;
					phase_d = ST_CV;
					pc_d    = '0;
					mdel_d  = 1'b0;
					hc      = psv_q ? HIST_SUPPORT : HIST_CONTROL;
					psv_d   = 1'b0;
					breath  = 1'b1;
				end else if (mcan_q && !pc_lt_ctl) begin
					pc_d   = '0;
					mcan_d = 1'b0;
				end else if (item.apnea_alarm) begin
					ins     = INSP_CTRL;
					kind    = KIND_CONTROL;
					ctl     = 1'b1;
					phase_d = ST_CV_APNEA;
					pc_d    = '0;
					mcan_d  = 1'b0;
					mdel_d  = 1'b0;
					breath  = 1'b1;
				end
			end
			ST_ASSIST: begin
				if (!pc_lt_ctl) begin
					pc_d   = '0;
					mcan_d = 1'b0;
				end
				if (ti_done) begin
					til_d   = ti_a;
					te_d    = '0;
					phase_d = ST_EXH;
					exh_d   = pc_d;
				end
			end
			ST_PSV: begin
				if (psv_end) begin
					til_d   = ti_a;
					te_d    = '0;
					phase_d = ST_EXH;
					exh_d   = pc_a;
					if (end_mark >= ctl_x) begin
						mdel_d = 1'b1;
					end
					if (psv_timed) begin
						pcode = PSEND_TIMED;
					end else if (item.high_pressure) begin
						pcode = PSEND_HIGHP;
					end else begin
						pcode = PSEND_FLOW;
					end
					pidx_d = next_slot(pidx_q);
				end
			end
			ST_CV, ST_CV_APNEA: begin
				if (ti_done) begin
					til_d   = ti_a;
					te_d    = '0;
					phase_d = (phase_in == ST_CV) ? ST_EXH : ST_EXH_APNEA;
					exh_d   = pc_a;
				end
			end
			ST_EXH_APNEA: begin
				if (item.insp_trigger) begin
					if (pc_lt_bkp) begin
						ins  = INSP_TRIG;
						kind = KIND_ASSIST;
						if (tally_d < cfg.exit_count) begin
							tally_d = tally_d + 2'd1;
						end
						if (tally_d >= cfg.exit_count) begin
							phase_d = ST_ASSIST;
							tally_d = 2'd0;
						end else begin
							phase_d = ST_CV_APNEA;
						end
						pc_d   = '0;
						mcan_d = 1'b0;
						hc     = HIST_ASSIST;
						breath = 1'b1;
					end
				end else if (!pc_lt_bkp) begin
					ins     = INSP_CTRL;
					kind    = KIND_CONTROL;
					ctl     = 1'b1;
					phase_d = ST_CV_APNEA;
					pc_d    = '0;
					mcan_d  = 1'b0;
					hc      = HIST_CONTROL;
					tally_d = 2'd0;
					breath  = 1'b1;
				end
			end
			ST_LEFT: begin
				phase_d = ST_LEFT;
			end
			default: phase_d = ST_LEFT;
		endcase

		// Advance the history ring and close the previous exhalation
		if (hc != HIST_NONE) begin
			hidx_d = next_slot(hidx_q);
		end
		if (breath) begin
			tel_d = te_d;
			ti_d  = '0;
			ar    = 1'b1;
		end
	end

	// Assemble the result of this step
	always_comb begin
		res.insp_type       = ins;
		res.breath_kind     = kind;
		res.controlled_flag = ctl;
		res.phase           = phase_d;
		res.ti_measured     = til_d[15:0];
		res.te_measured     = tel_d[15:0];
		res.history_code    = hc;
		res.history_slot    = (hc != HIST_NONE) ? 3'(hidx_q) : 3'd0;
		res.ps_end_code     = pcode;
		res.ps_end_slot     = (pcode != PSEND_NONE) ? 3'(pidx_q) : 3'd0;
		res.apnea_restart   = ar;
	end

	// Commit state on each processed step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ST_START;
			fbs_q   <= 1'b0;
			te_q    <= '0;
			ti_q    <= '0;
			pc_q    <= '0;
			exh_q   <= '0;
			til_q   <= '0;
			tel_q   <= '0;
			hidx_q  <= '0;
			pidx_q  <= '0;
			psv_q   <= 1'b0;
			mdel_q  <= 1'b0;
			mcan_q  <= 1'b0;
			tally_q <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			fbs_q   <= fbs_d;
			te_q    <= te_d;
			ti_q    <= ti_d;
			pc_q    <= pc_d;
			exh_q   <= exh_d;
			til_q   <= til_d;
			tel_q   <= tel_d;
			hidx_q  <= hidx_d;
			pidx_q  <= pidx_d;
			psv_q   <= psv_d;
			mdel_q  <= mdel_d;
			mcan_q  <= mcan_d;
			tally_q <= tally_d;
		end
	end

endmodule

@@ src/bcs_checker.sv @@
// ---------------------------------------------------------------------------
// Breath cycle sequencer port checker
// Watches the result stream of the sequencer for handshake and field rules.
// ---------------------------------------------------------------------------
`include "simv_breath_cycle_sequencer_unit_macros.svh"

module bcs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [bcs_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import bcs_pkg::*;

	result_t o;

	assign o = result_t'(m_tdata[$bits(result_t)-1:0]);

	// A stalled result stays offered and unchanged
	`BCS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`BCS_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

	// Any inspiration start records a breath and restarts the apnea timers
	`BCS_ASSERT_SAME(a_insp_restart, m_tvalid && o.insp_type != INSP_NONE, o.apnea_restart && o.breath_kind != KIND_NONE, "inspiration without breath record")

	// Idle ring entries and missing breaths report zero slots and flags
	`BCS_ASSERT_SAME(a_idle_fields, m_tvalid && o.history_code == HIST_NONE && o.ps_end_code == PSEND_NONE, o.history_slot == 3'd0 && o.ps_end_slot == 3'd0, "slot set without entry")
	`BCS_ASSERT_SAME(a_ctl_flag, m_tvalid && o.breath_kind == KIND_NONE, !o.controlled_flag && o.insp_type == INSP_NONE, "controlled flag without breath")

endmodule

bind simv_breath_cycle_sequencer_unit bcs_checker u_bcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
